FILE: src/ttu_pkg.sv
// ----------------------------------------------------------------------------
// Transposition table package
// Shared types, operation and bound codes, and defaults for the
// transposition table unit.
// ----------------------------------------------------------------------------
package ttu_pkg;

    // Default table size and mate threshold after reset.
    localparam int unsigned TABLE_ENTRIES_DEFAULT = 4096;
    localparam logic [14:0] MATE_THRESHOLD_RESET  = 15'd29936;

    // Operation codes.
    localparam logic [1:0] OP_PROBE = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Bound codes.
    localparam logic [1:0] BOUND_UPPER = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_EXACT = 2'd2;

    // Score limits used for saturation.
    localparam logic signed [16:0] SCORE_MAX = 17'sd32767;
    localparam logic signed [16:0] SCORE_MIN = -17'sd32768;

    // Input beat.
    typedef struct packed {
        logic [1:0]         operation;
        logic [63:0]        position_key;
        logic [24:0]        move;
        logic signed [15:0] score;
        logic [1:0]         bound_kind;
        logic [5:0]         depth;
        logic signed [15:0] alpha_bound;
        logic signed [15:0] beta_bound;
        logic [5:0]         ply;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic               hit;
        logic               cutoff;
        logic [24:0]        best_move;
        logic signed [15:0] adjusted_score;
        logic [31:0]        fresh_writes;
        logic [31:0]        replacements;
    } rsp_t;

    // One table entry as held in memory.
    typedef struct packed {
        logic [63:0]        key;
        logic [24:0]        move;
        logic signed [15:0] score;
        logic [5:0]         depth;
        logic [1:0]         bound;
    } slot_t;

    // Decision from the evaluation logic back to the controller.
    typedef struct packed {
        logic               hit;
        logic               cutoff;
        logic [24:0]        best_move;
        logic signed [15:0] adjusted_score;
        logic               wr_en;
        logic               fresh_inc;
        logic               repl_inc;
        slot_t              new_slot;
    } calc_t;

endpackage

FILE: src/ttu_mem.sv
// ----------------------------------------------------------------------------
// Transposition table memory
// Single-port-write, single-port-read synchronous RAM with registered
// read data.
// ----------------------------------------------------------------------------
module ttu_mem #(
    parameter int unsigned DEPTH = ttu_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int unsigned IDX_W = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ttu_pkg::slot_t       wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output ttu_pkg::slot_t       rd_data
);

    ttu_pkg::slot_t mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/ttu_calc.sv
// ----------------------------------------------------------------------------
// Transposition table evaluation
// Given the request and the entry read from memory, decides the probe
// result and, for a store, whether and what to write back.
// ----------------------------------------------------------------------------
module ttu_calc (
    input  ttu_pkg::req_t  req,
    input  ttu_pkg::slot_t stored,
    input  logic [14:0]    mate_threshold,
    output ttu_pkg::calc_t result
);

    localparam logic signed [16:0] SCORE_MAX_L = ttu_pkg::SCORE_MAX;
    localparam logic signed [16:0] SCORE_MIN_L = ttu_pkg::SCORE_MIN;

    logic signed [16:0] thr_pos;
    logic signed [16:0] thr_neg;
    logic signed [16:0] st_score;
    logic signed [16:0] in_score;
    logic signed [16:0] alpha_ext;
    logic signed [16:0] beta_ext;
    logic signed [16:0] ply_ext;
    logic signed [16:0] adj;
    logic signed [16:0] push;
    logic signed [16:0] sat;
    logic               key_match;

    // Sign-extended operands for the threshold and window compares.
    assign thr_pos   = signed'({2'b00, mate_threshold});
    assign thr_neg   = -thr_pos;
    assign st_score  = signed'({stored.score[15], stored.score});
    assign in_score  = signed'({req.score[15], req.score});
    assign alpha_ext = signed'({req.alpha_bound[15], req.alpha_bound});
    assign beta_ext  = signed'({req.beta_bound[15], req.beta_bound});
    assign ply_ext   = signed'({11'd0, req.ply});
    assign key_match = (stored.key == req.position_key);

    // Probe side: mate scores are pulled toward zero by ply.
    always_comb begin
        if (st_score > thr_pos) begin
            adj = st_score - ply_ext;
        end else if (st_score < thr_neg) begin
            adj = st_score + ply_ext;
        end else begin
            adj = st_score;
        end
    end

    // Store side: mate scores are pushed away from zero, then saturated.
    always_comb begin
        if (in_score > thr_pos) begin
            push = in_score + ply_ext;
        end else if (in_score < thr_neg) begin
            push = in_score - ply_ext;
        end else begin
            push = in_score;
        end
        if (push > SCORE_MAX_L) begin
            sat = SCORE_MAX_L;
        end else if (push < SCORE_MIN_L) begin
            sat = SCORE_MIN_L;
        end else begin
            sat = push;
        end
    end

    // Per-operation decision.
    always_comb begin
        result                  = '0;
        result.new_slot.key     = req.position_key;
        result.new_slot.move    = req.move;
        result.new_slot.score   = sat[15:0];
        result.new_slot.depth   = req.depth;
        result.new_slot.bound   = req.bound_kind;
        case (req.operation)
            ttu_pkg::OP_PROBE: begin
                if (key_match) begin
                    result.hit       = 1'b1;
                    result.best_move = stored.move;
                    if (stored.depth >= req.depth) begin
                        result.adjusted_score = adj[15:0];
                        case (stored.bound)
                            ttu_pkg::BOUND_UPPER: begin
                                if (adj <= alpha_ext) begin
                                    result.adjusted_score = req.alpha_bound;
                                    result.cutoff         = 1'b1;
                                end
                            end
                            ttu_pkg::BOUND_LOWER: begin
                                if (adj >= beta_ext) begin
                                    result.adjusted_score = req.beta_bound;
                                    result.cutoff         = 1'b1;
                                end
                            end
                            ttu_pkg::BOUND_EXACT: begin
                                result.cutoff = 1'b1;
                            end
                            default: begin
                                result.cutoff = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ttu_pkg::OP_STORE: begin
                if (stored.key == 64'd0) begin
                    result.wr_en     = 1'b1;
                    result.fresh_inc = 1'b1;
                end else if (stored.depth <= req.depth) begin
                    result.wr_en    = 1'b1;
                    result.repl_inc = 1'b1;
                end
            end
            default: begin
                result.wr_en = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/transposition_table_unit.sv
// ----------------------------------------------------------------------------
// Transposition table unit
// Direct-mapped table of search results with probe, store and clear.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive as beats on the s_ channel (valid/ready) and each one
// produces exactly one result beat on the m_ channel (valid/ready). The
// table index is the low bits of position_key.
// A probe or store issues the synchronous memory read at acceptance, then,
// in the lookup state, evaluates, writes the entry back and loads the output
// register. The next request is taken only once that write-back is done, so
// a new request is never taken while another is still in lookup.
// A clear returns its result in the cycle after acceptance, then sweeps
// the memory one entry a cycle over all TABLE_ENTRIES entries, during which
// s_ready stays low.
// After reset the same sweep runs over all TABLE_ENTRIES entries before the
// first request is taken; mate_threshold returns to 29936 and both
// counters to zero. cfg_wr_en writes cfg_wr_data into mate_threshold, registered.
// A new request is taken only when the output register is empty or is
// being emptied in that cycle; a stalled receiver holds the block.
// ----------------------------------------------------------------------------
module transposition_table_unit #(
    parameter int unsigned TABLE_ENTRIES = ttu_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ttu_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ttu_pkg::rsp_t m_data,
    input  logic          cfg_wr_en,
    input  logic [14:0]   cfg_wr_data
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_ptr_reg, clr_ptr_next;
    logic [31:0]      fresh_reg, fresh_next;
    logic [31:0]      repl_reg, repl_next;
    logic             m_valid_reg, m_valid_next;
    logic [14:0]      thr_reg;
    ttu_pkg::req_t    req_reg;
    ttu_pkg::rsp_t    rsp_reg, rsp_next;
    logic             rsp_load;

    logic             accept;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ttu_pkg::slot_t   wr_data;
    ttu_pkg::slot_t   rd_data;
    ttu_pkg::calc_t   calc;

    // Handshake.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    // Table memory; the read is issued at acceptance.
    ttu_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (s_data.position_key[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Evaluation of the entry read for the held request.
    ttu_calc u_calc (
        .req            (req_reg),
        .stored         (rd_data),
        .mate_threshold (thr_reg),
        .result         (calc)
    );

    // Write port: the clearing sweep or the write-back of a store.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_reg;
            wr_data = '0;
        end else begin
            wr_en   = (state_reg == ST_LOOKUP) && calc.wr_en;
            wr_addr = req_reg.position_key[IDX_W-1:0];
            wr_data = calc.new_slot;
        end
    end

    // Sequencer, counters and result assembly.
    always_comb begin
        state_next   = state_reg;
        clr_ptr_next = clr_ptr_reg;
        fresh_next   = fresh_reg;
        repl_next    = repl_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rsp_load     = 1'b0;
        rsp_next     = '0;
        case (state_reg)
            ST_CLEAR: begin
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.operation == ttu_pkg::OP_CLEAR) begin
                        fresh_next            = '0;
                        clr_ptr_next          = '0;
                        state_next            = ST_CLEAR;
                        rsp_load              = 1'b1;
                        m_valid_next          = 1'b1;
                        rsp_next.fresh_writes = '0;
                        rsp_next.replacements = repl_reg;
                    end else begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                if (calc.fresh_inc) begin
                    fresh_next = fresh_reg + 32'd1;
                end
                if (calc.repl_inc) begin
                    repl_next = repl_reg + 32'd1;
                end
                state_next              = ST_IDLE;
                rsp_load                = 1'b1;
                m_valid_next            = 1'b1;
                rsp_next.hit            = calc.hit;
                rsp_next.cutoff         = calc.cutoff;
                rsp_next.best_move      = calc.best_move;
                rsp_next.adjusted_score = calc.adjusted_score;
                rsp_next.fresh_writes   = fresh_next;
                rsp_next.replacements   = repl_next;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
            fresh_reg   <= '0;
            repl_reg    <= '0;
            m_valid_reg <= 1'b0;
            thr_reg     <= ttu_pkg::MATE_THRESHOLD_RESET;
        end else begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            fresh_reg   <= fresh_next;
            repl_reg    <= repl_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
        if (rsp_load) begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef ASSERT_OFF
    // No request may enter while the table is being swept.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request accepted during clearing sweep");

    // The output register is always free when a lookup completes.
    a_out_free_in_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP) |-> !m_valid_reg)
        else $error("lookup result would overwrite a pending beat");

    // A lookup always follows an accepted probe or store.
    a_lookup_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.operation != ttu_pkg::OP_CLEAR) |=> (state_reg == ST_LOOKUP))
        else $error("accepted request did not enter lookup");

    // The fresh-write count only steps by one or returns to zero.
    a_fresh_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (fresh_reg != $past(fresh_reg)) |->
            (fresh_reg == $past(fresh_reg) + 32'd1) || (fresh_reg == 32'd0))
        else $error("fresh-write count changed unexpectedly");
`endif

endmodule

FILE: test/transposition_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transposition table unit testbench
// Drives probe, store and clear beats into the table. Each accepted beat is
// run through a behavioral copy of the table, which gives the expected result
// beat. A short table of directed beats comes first. Random phases follow,
// each with a mate threshold write, and with idling on each side set per pair.
// ----------------------------------------------------------------------------
module transposition_table_unit_tb;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [1:0] BOUND_NONE = 2'd3;

    localparam int unsigned TBL             = ttu_pkg::TABLE_ENTRIES_DEFAULT;
    localparam int          POOL_SIZE       = 24;
    localparam int          ITEMS_PER_PHASE = 330;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          TIMEOUT_NS      = 8_000_000;

    // One row of the directed table. Where want_typed is set, the result is
    // written out by hand; otherwise the table copy supplies it.
    typedef struct {
        ttu_pkg::req_t beat;
        bit            want_typed;
        ttu_pkg::rsp_t want;
    } row_t;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    ttu_pkg::req_t s_data;
    logic          m_valid;
    logic          m_ready;
    ttu_pkg::rsp_t m_data;
    logic          cfg_wr_en;
    logic [14:0]   cfg_wr_data;

    // Behavioral copy of the table, its counters and its threshold.
    logic [63:0] tt_key [TBL];
    logic [24:0] tt_move [TBL];
    int          tt_score [TBL];
    logic [5:0]  tt_depth [TBL];
    logic [1:0]  tt_bound [TBL];
    logic [31:0] tt_fresh;
    logic [31:0] tt_replaced;
    int          tt_mate_thr;

    ttu_pkg::rsp_t results_due[$];
    row_t          directed_rows[$];
    logic [63:0]   key_pool [POOL_SIZE];
    int            mismatch_count = 0;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_requests = 0;

    transposition_table_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clears the copy of the table; the counters are handled by the caller.
    function automatic void wipe_copy();
        for (int i = 0; i < TBL; i++) begin
            tt_key[i]   = '0;
            tt_move[i]  = '0;
            tt_score[i] = 0;
            tt_depth[i] = '0;
            tt_bound[i] = '0;
        end
    endfunction

    // Works out the result beat of one request and updates the table copy.
    function automatic ttu_pkg::rsp_t table_response(input ttu_pkg::req_t r);
        ttu_pkg::rsp_t o;
        int            slot;
        int            s;
        int            pl;
        bit            do_write;
        o    = '0;
        slot = int'(r.position_key % TBL);
        pl   = int'(r.ply);
        case (r.operation)
            ttu_pkg::OP_PROBE: begin
                if (tt_key[slot] == r.position_key) begin
                    o.hit       = 1'b1;
                    o.best_move = tt_move[slot];
                    if (tt_depth[slot] >= r.depth) begin
                        // Mate scores come back pulled toward zero by ply.
                        s = tt_score[slot];
                        if (s > tt_mate_thr)
                            s = s - pl;
                        else if (s < -tt_mate_thr)
                            s = s + pl;
                        case (tt_bound[slot])
                            ttu_pkg::BOUND_UPPER: begin
                                if (s <= int'(r.alpha_bound)) begin
                                    s        = int'(r.alpha_bound);
                                    o.cutoff = 1'b1;
                                end
                            end
                            ttu_pkg::BOUND_LOWER: begin
                                if (s >= int'(r.beta_bound)) begin
                                    s        = int'(r.beta_bound);
                                    o.cutoff = 1'b1;
                                end
                            end
                            ttu_pkg::BOUND_EXACT: o.cutoff = 1'b1;
                            default: ;
                        endcase
                        o.adjusted_score = s[15:0];
                    end
                end
            end
            ttu_pkg::OP_STORE: begin
                do_write = 1'b1;
                if (tt_key[slot] == '0)
                    tt_fresh = tt_fresh + 1;
                else if (tt_depth[slot] > r.depth)
                    do_write = 1'b0;
                else
                    tt_replaced = tt_replaced + 1;
                if (do_write) begin
                    // Mate scores go in pushed away from zero, then saturate.
                    s = int'(r.score);
                    if (s > tt_mate_thr)
                        s = s + pl;
                    else if (s < -tt_mate_thr)
                        s = s - pl;
                    if (s > 32767)
                        s = 32767;
                    if (s < -32768)
                        s = -32768;
                    tt_key[slot]   = r.position_key;
                    tt_move[slot]  = r.move;
                    tt_score[slot] = s;
                    tt_depth[slot] = r.depth;
                    tt_bound[slot] = r.bound_kind;
                end
            end
            ttu_pkg::OP_CLEAR: begin
                wipe_copy();
                tt_fresh = '0;
            end
            default: ;
        endcase
        o.fresh_writes = tt_fresh;
        o.replacements = tt_replaced;
        return o;
    endfunction

    function automatic ttu_pkg::req_t mk_beat(input logic [1:0] op, input logic [63:0] key,
                                              input int mv, input int sc,
                                              input logic [1:0] bnd, input int dep,
                                              input int alpha, input int beta,
                                              input int ply);
        ttu_pkg::req_t b;
        b.operation    = op;
        b.position_key = key;
        b.move         = 25'(mv);
        b.score        = 16'(sc);
        b.bound_kind   = bnd;
        b.depth        = 6'(dep);
        b.alpha_bound  = 16'(alpha);
        b.beta_bound   = 16'(beta);
        b.ply          = 6'(ply);
        return b;
    endfunction

    function automatic ttu_pkg::rsp_t mk_rsp(input int hit, input int cut, input int mv,
                                             input int sc, input int fresh, input int repl);
        ttu_pkg::rsp_t o;
        o.hit            = 1'(hit);
        o.cutoff         = 1'(cut);
        o.best_move      = 25'(mv);
        o.adjusted_score = 16'(sc);
        o.fresh_writes   = 32'(fresh);
        o.replacements   = 32'(repl);
        return o;
    endfunction

    task automatic add_row(input ttu_pkg::req_t b, input int typed, input ttu_pkg::rsp_t want);
        row_t row;
        row.beat       = b;
        row.want_typed = (typed != 0);
        row.want       = want;
        directed_rows.push_back(row);
    endtask

    // Score picker: plain values, values around the mate threshold on both
    // sides, and values near the ends of the range.
    function automatic logic [15:0] pick_score();
        int s;
        case ($urandom_range(0, 5))
            0: s = int'($urandom_range(0, 65535)) - 32768;
            1: s = int'($urandom_range(0, 400)) - 200;
            2: s = tt_mate_thr + int'($urandom_range(0, 4)) - 2;
            3: s = -tt_mate_thr + int'($urandom_range(0, 4)) - 2;
            4: s = 32767 - int'($urandom_range(0, 70));
            default: s = -32768 + int'($urandom_range(0, 70));
        endcase
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return s[15:0];
    endfunction

    // Random request. Most keys come from a small pool that shares a few
    // slots, so stores, replacements, skips and hits all happen often.
    function automatic ttu_pkg::req_t random_beat();
        ttu_pkg::req_t b;
        int            r;
        int            slot;
        int            d;
        r = $urandom_range(0, 999);
        if (r < 5)
            b.operation = ttu_pkg::OP_CLEAR;
        else if (r < 25)
            b.operation = OP_NONE;
        else if (r < 510)
            b.operation = ttu_pkg::OP_STORE;
        else
            b.operation = ttu_pkg::OP_PROBE;
        r = $urandom_range(0, 99);
        if (r < 85)
            b.position_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 96)
            b.position_key = {$urandom, $urandom};
        else
            b.position_key = '0;
        b.move        = 25'($urandom);
        b.score       = pick_score();
        b.bound_kind  = ($urandom_range(0, 49) == 0) ? BOUND_NONE
                                                     : 2'($urandom_range(0, 2));
        b.alpha_bound = pick_score();
        b.beta_bound  = pick_score();
        b.ply         = 6'($urandom);
        // Depth is often chosen next to the stored one so that equal and
        // deeper entries both show up instead of every slot drifting deep.
        slot = int'(b.position_key % TBL);
        if ($urandom_range(0, 99) < 45) begin
            d = int'(tt_depth[slot]) + int'($urandom_range(0, 2)) - 1;
            if (d < 0)
                d = 0;
            if (d > 63)
                d = 63;
        end else begin
            d = $urandom_range(0, 63);
        end
        b.depth = 6'(d);
        return b;
    endfunction

    // Offers one beat, with an optional gap first, and records its result.
    task automatic send_beat(input ttu_pkg::req_t b, input bit typed,
                             input ttu_pkg::rsp_t want);
        ttu_pkg::rsp_t pred;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        pred = table_response(b);
        results_due.push_back(typed ? want : pred);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
    endtask

    // Threshold writes only once the block is drained and any clear sweep
    // has run to its end.
    task automatic write_mate_threshold(input logic [14:0] value);
        wait_for_results();
        repeat (TBL + 8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tt_mate_thr = int'(value);
    endtask

    // Compares one result beat with the oldest expected one.
    task automatic check_result(input ttu_pkg::rsp_t got);
        ttu_pkg::rsp_t want;
        if (results_due.size() == 0) begin
            $error("result beat with nothing outstanding: %h", got);
            mismatch_count++;
            return;
        end
        want = results_due.pop_front();
        if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            mismatch_count++;
        end
        if (got.cutoff !== want.cutoff) begin
            $error("cutoff: expected %0d, actual %0d", want.cutoff, got.cutoff);
            mismatch_count++;
        end
        if (got.best_move !== want.best_move) begin
            $error("best_move: expected %h, actual %h", want.best_move, got.best_move);
            mismatch_count++;
        end
        if (got.adjusted_score !== want.adjusted_score) begin
            $error("adjusted_score: expected %0d, actual %0d",
                   $signed(want.adjusted_score), $signed(got.adjusted_score));
            mismatch_count++;
        end
        if (got.fresh_writes !== want.fresh_writes) begin
            $error("fresh_writes: expected %0d, actual %0d",
                   want.fresh_writes, got.fresh_writes);
            mismatch_count++;
        end
        if (got.replacements !== want.replacements) begin
            $error("replacements: expected %0d, actual %0d",
                   want.replacements, got.replacements);
            mismatch_count++;
        end
    endtask

    // Result side: checks each beat taken and decides the next ready,
    // including the long hold-off whenever a new one is requested.
    initial begin : result_sink
        int hold_left;
        int holds_seen;
        bit rdy;
        hold_left  = 0;
        holds_seen = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                check_result(m_data);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                rdy = ($urandom_range(0, 99) >= recv_idle_pct);
            end
            m_ready <= rdy;
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [11:0] pool_slots [6];
        logic [14:0] thr;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_idle_pct = 35;
        recv_idle_pct = 53;
        wipe_copy();
        tt_fresh    = '0;
        tt_replaced = '0;
        tt_mate_thr = int'(ttu_pkg::MATE_THRESHOLD_RESET);

        // Key pool: 24 keys spread over six slots.
        for (int i = 0; i < 6; i++)
            pool_slots[i] = 12'($urandom);
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i]        = {$urandom, $urandom};
            key_pool[i][11:0]  = pool_slots[i % 6];
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats at the reset threshold.
        // Key zero hits a cleared entry, and a miss.
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h0, 0, 0, ttu_pkg::BOUND_UPPER, 0, 0, 0, 0),
                1, mk_rsp(1, 1, 0, 0, 0, 0));
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h1234_5678_9ABC_D005, 0, 0,
                        ttu_pkg::BOUND_UPPER, 0, 0, 0, 0),
                1, mk_rsp(0, 0, 0, 0, 0, 0));
        // Largest key, move, depth and ply; the mate score saturates on store.
        add_row(mk_beat(ttu_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 'h1FFFFFF, 32767,
                        ttu_pkg::BOUND_EXACT, 63, -32768, 32767, 63),
                1, mk_rsp(0, 0, 0, 0, 1, 0));
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0,
                        ttu_pkg::BOUND_UPPER, 63, 0, 0, 63),
                1, mk_rsp(1, 1, 'h1FFFFFF, 32704, 1, 0));
        // Most negative score, upper bound, then too shallow a probe.
        add_row(mk_beat(ttu_pkg::OP_STORE, 64'h1001, 0, -32768, ttu_pkg::BOUND_UPPER,
                        10, 0, 0, 40),
                1, mk_rsp(0, 0, 0, 0, 2, 0));
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h1001, 0, 0, ttu_pkg::BOUND_UPPER,
                        10, 32767, 0, 40),
                1, mk_rsp(1, 1, 0, 32767, 2, 0));
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h1001, 0, 0, ttu_pkg::BOUND_UPPER,
                        11, 0, 0, 0),
                1, mk_rsp(1, 0, 0, 0, 2, 0));
        // Same slot, other key: shallower store is skipped, equal depth replaces.
        add_row(mk_beat(ttu_pkg::OP_STORE, 64'h8000_0000_0000_1001, 'h0AAAAAA, 500,
                        ttu_pkg::BOUND_LOWER, 5, 0, 0, 0),
                1, mk_rsp(0, 0, 0, 0, 2, 0));
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h8000_0000_0000_1001, 0, 0,
                        ttu_pkg::BOUND_UPPER, 0, 0, 0, 0),
                1, mk_rsp(0, 0, 0, 0, 2, 0));
        add_row(mk_beat(ttu_pkg::OP_STORE, 64'h8000_0000_0000_1001, 'h1555555, 100,
                        ttu_pkg::BOUND_LOWER, 10, 0, 0, 5),
                1, mk_rsp(0, 0, 0, 0, 2, 1));
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h8000_0000_0000_1001, 0, 0,
                        ttu_pkg::BOUND_UPPER, 0, 0, -32768, 5), 0, '0);
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h8000_0000_0000_1001, 0, 0,
                        ttu_pkg::BOUND_UPPER, 10, -32768, 32767, 5), 0, '0);
        // Stores under key zero keep counting as fresh; bound code three.
        add_row(mk_beat(ttu_pkg::OP_STORE, 64'h0, 123, 5, BOUND_NONE, 7, 0, 0, 0), 1,
                mk_rsp(0, 0, 0, 0, 3, 1));
        add_row(mk_beat(ttu_pkg::OP_STORE, 64'h0, 456, 6, BOUND_NONE, 7, 0, 0, 0), 1,
                mk_rsp(0, 0, 0, 0, 4, 1));
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h0, 0, 0, ttu_pkg::BOUND_UPPER,
                        7, 32767, -32768, 0), 0, '0);
        // Unused operation code does nothing.
        add_row(mk_beat(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 'h1FFFFFF, -1, BOUND_NONE,
                        63, -1, -1, 63), 1, mk_rsp(0, 0, 0, 0, 4, 1));
        // Negative mate score just past the threshold.
        add_row(mk_beat(ttu_pkg::OP_STORE, 64'h5A5A_0000_0000_0002, 1, -29937,
                        ttu_pkg::BOUND_UPPER, 1, 0, 0, 3), 0, '0);
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h5A5A_0000_0000_0002, 0, 0,
                        ttu_pkg::BOUND_UPPER, 1, -32768, 0, 3), 0, '0);
        // Clear keeps the replacement count and empties the table.
        add_row(mk_beat(ttu_pkg::OP_CLEAR, 64'h0, 0, 0, ttu_pkg::BOUND_UPPER, 0, 0, 0, 0),
                1, mk_rsp(0, 0, 0, 0, 0, 1));
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0,
                        ttu_pkg::BOUND_UPPER, 0, 0, 0, 0),
                1, mk_rsp(0, 0, 0, 0, 0, 1));
        add_row(mk_beat(ttu_pkg::OP_PROBE, 64'h0, 0, 0, ttu_pkg::BOUND_LOWER, 0, 0, 0, 0),
                0, '0);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].want_typed,
                      directed_rows[i].want);

        // Random phases: two thresholds per idling mode.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: thr = 15'd0;
                1: thr = 15'd32767;
                2: thr = 15'($urandom_range(0, 32767));
                3: thr = ttu_pkg::MATE_THRESHOLD_RESET;
                4: thr = 15'd1000;
                default: thr = 15'd32767;
            endcase
            write_mate_threshold(thr);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Long receiver hold-off while beats keep coming.
                if (ph == 0 && n == 100)
                    hold_requests++;
                // Sender pauses until the block has drained.
                if (ph == 3 && n == 150)
                    wait_for_results();
                send_beat(random_beat(), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
